// ----- rtl/ffha_pkg.sv -----
// Shared constants, types and status codes of the first-fit heap allocator.
// Depends on nothing; every other file of the block imports it.
package ffha_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int ARENA_BYTES  = 65536;
	localparam int HEADER_BYTES = 16;
	localparam int ALIGN_BYTES  = 8;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int OFF_W = 16;
	localparam int LEN_W = 17;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_ZERO    = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic             taken;
	} ent_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		ent_t             wr_data;
	} tbl_cmd_t;

	localparam ent_t RESET_ENT = '{off: '0, len: LEN_W'(ARENA_BYTES), taken: 1'b0};

endpackage

// ----- rtl/ffha_table.sv -----
// Block table memory: one read and one write port, registered read data.
// Depends on ffha_pkg. Entry 0 reads as the whole free arena until first written.
module ffha_table (
	input  logic               clk,
	input  logic               arst_n,
	input  ffha_pkg::tbl_cmd_t cmd,
	output ffha_pkg::ent_t     rd_data
);
	import ffha_pkg::*;

	ent_t mem [MAX_BLOCKS];
	ent_t rd_q;
	logic e0_written_q;
	logic rd_fresh_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_written_q <= 1'b0;
			rd_fresh_q   <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_fresh_q <= (cmd.rd_addr == '0) && !e0_written_q;
			end
			if (cmd.wr_en && cmd.wr_addr == '0) begin
				e0_written_q <= 1'b1;
			end
		end
	end

	assign rd_data = rd_fresh_q ? RESET_ENT : rd_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: request capture, sequencer, result register.
// Depends on ffha_pkg and ffha_table.
//
//  Channel  Signals                                        Direction
//  request  req_valid req_ready func request_bytes         in
//           release_offset
//  result   rsp_valid rsp_ready status payload_offset      out
//
// One request is worked at a time. A request reads each table entry that it scans, and
// a split or merge that shifts the table reads and writes each entry that it moves; the
// entries scanned and moved together never pass the table size. Each request ends by
// passing from the result state to the idle state, where the next request is taken.
// The single read port of the table paces the scan and the shifts.
// Reset leaves one free block that covers the arena and needs no clearing pass.
// A new request is taken while an earlier result still waits; a held result stalls
// only the end of the next request.
module first_fit_heap_allocator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic                     func,
	input  logic [15:0]              request_bytes,
	input  logic [15:0]              release_offset,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [1:0]               status,
	output logic [15:0]              payload_offset
);
	import ffha_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_SCAN_RD  = 14'b00000000000010,
		S_SCAN_CHK = 14'b00000000000100,
		S_NXT_CHK  = 14'b00000000001000,
		S_PRV_RD   = 14'b00000000010000,
		S_PRV_CHK  = 14'b00000000100000,
		S_MERGE_WR = 14'b00000001000000,
		S_DN_RD    = 14'b00000010000000,
		S_DN_WR    = 14'b00000100000000,
		S_UP_RD    = 14'b00001000000000,
		S_UP_WR    = 14'b00010000000000,
		S_SPLIT_HI = 14'b00100000000000,
		S_SPLIT_LO = 14'b01000000000000,
		S_RESULT   = 14'b10000000000000
	} state_t;

	localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);

	state_t           state_q;
	logic [CNT_W-1:0] total_q;
	logic             rsp_valid_q;
	logic             func_q;
	logic [LEN_W-1:0] need_q;
	logic [OFF_W-1:0] rel_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] ptr_q;
	logic [1:0]       k_q;
	logic             nf_q;
	logic             pf_q;
	ent_t             cur_q;
	ent_t             nxt_q;
	ent_t             prv_q;
	status_t          st_q;
	logic [OFF_W-1:0] pay_q;
	status_t          rsp_status_q;
	logic [OFF_W-1:0] rsp_pay_q;

	tbl_cmd_t cmd;
	ent_t     rd;

	logic [17:0]      need_full;
	logic [LEN_W-1:0] spare;
	logic             fit;
	logic             split;
	logic             hit_free;
	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W-1:0] base;
	logic [LEN_W-1:0] merge_len;
	logic [1:0]       k_new;

	ffha_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd)
	);

	assign need_full = ((18'(request_bytes) + 18'(ALIGN_BYTES - 1))
		& ~18'(ALIGN_BYTES - 1)) + 18'(HEADER_BYTES);
	assign spare     = rd.len - need_q;
	assign fit       = !rd.taken && (rd.len >= need_q);
	assign split     = spare > HDR;
	assign hit_free  = ({1'b0, rd.off} + HDR) == {1'b0, rel_q};
	assign idx_inc   = idx_q + CNT_W'(1);
	assign base      = pf_q ? (idx_q - CNT_W'(1)) : idx_q;
	assign merge_len = cur_q.len + (nf_q ? nxt_q.len : '0) + (pf_q ? prv_q.len : '0);
	assign k_new     = {1'b0, nf_q} + {1'b0, pf_q};

	assign req_ready      = (state_q == S_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_status_q;
	assign payload_offset = rsp_pay_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_SCAN_RD: begin
				cmd.rd_en   = idx_q < total_q;
				cmd.rd_addr = idx_q[IDX_W-1:0];
			end
			S_SCAN_CHK: begin
				if (!func_q && fit && !split) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = idx_q[IDX_W-1:0];
					cmd.wr_data = '{off: rd.off, len: rd.len, taken: 1'b1};
				end
				if (func_q && hit_free && rd.taken && idx_inc < total_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = idx_inc[IDX_W-1:0];
				end
			end
			S_PRV_RD: begin
				cmd.rd_en   = idx_q != '0;
				cmd.rd_addr = base[IDX_W-1:0] - IDX_W'(1) + IDX_W'(pf_q);
			end
			S_MERGE_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = base[IDX_W-1:0];
				cmd.wr_data = '{off: pf_q ? prv_q.off : cur_q.off, len: merge_len,
					taken: 1'b0};
			end
			S_DN_RD: begin
				cmd.rd_en   = ptr_q < total_q;
				cmd.rd_addr = ptr_q[IDX_W-1:0];
			end
			S_DN_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = ptr_q[IDX_W-1:0] - IDX_W'(k_q);
				cmd.wr_data = rd;
			end
			S_UP_RD: begin
				cmd.rd_en   = ptr_q > idx_inc;
				cmd.rd_addr = ptr_q[IDX_W-1:0] - IDX_W'(1);
			end
			S_UP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = ptr_q[IDX_W-1:0];
				cmd.wr_data = rd;
			end
			S_SPLIT_HI: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = idx_inc[IDX_W-1:0];
				cmd.wr_data = '{off: cur_q.off + need_q[OFF_W-1:0],
					len: cur_q.len - need_q, taken: 1'b0};
			end
			S_SPLIT_LO: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = idx_q[IDX_W-1:0];
				cmd.wr_data = '{off: cur_q.off, len: need_q, taken: 1'b1};
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= CNT_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= (state_q == S_RESULT) || (rsp_valid_q && !rsp_ready);
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (!func && request_bytes == '0) ? S_RESULT : S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= (idx_q < total_q) ? S_SCAN_CHK : S_RESULT;
				end
				S_SCAN_CHK: begin
					if (!func_q && fit) begin
						if (!split) begin
							state_q <= S_RESULT;
						end else if (total_q >= CNT_W'(MAX_BLOCKS)) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_UP_RD;
						end
					end else if (func_q && hit_free) begin
						if (!rd.taken) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= (idx_inc < total_q) ? S_NXT_CHK : S_PRV_RD;
						end
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_NXT_CHK: begin
					state_q <= S_PRV_RD;
				end
				S_PRV_RD: begin
					state_q <= (idx_q != '0) ? S_PRV_CHK : S_MERGE_WR;
				end
				S_PRV_CHK: begin
					state_q <= S_MERGE_WR;
				end
				S_MERGE_WR: begin
					state_q <= (k_new == 2'd0) ? S_RESULT : S_DN_RD;
				end
				S_DN_RD: begin
					if (ptr_q < total_q) begin
						state_q <= S_DN_WR;
					end else begin
						total_q <= total_q - CNT_W'(k_q);
						state_q <= S_RESULT;
					end
				end
				S_DN_WR: begin
					state_q <= S_DN_RD;
				end
				S_UP_RD: begin
					state_q <= (ptr_q > idx_inc) ? S_UP_WR : S_SPLIT_HI;
				end
				S_UP_WR: begin
					state_q <= S_UP_RD;
				end
				S_SPLIT_HI: begin
					state_q <= S_SPLIT_LO;
				end
				S_SPLIT_LO: begin
					total_q <= total_q + CNT_W'(1);
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				need_q <= need_full[LEN_W-1:0];
				rel_q  <= release_offset;
				idx_q  <= '0;
				nf_q   <= 1'b0;
				pf_q   <= 1'b0;
				pay_q  <= '0;
				st_q   <= ST_ZERO;
			end
			S_SCAN_RD: begin
				st_q <= func_q ? ST_BADFREE : ST_NOSPACE;
			end
			S_SCAN_CHK: begin
				cur_q <= rd;
				ptr_q <= total_q;
				if (!func_q && fit) begin
					if (!split) begin
						st_q  <= ST_OK;
						pay_q <= rd.off + OFF_W'(HEADER_BYTES);
					end else begin
						st_q <= ST_NOSPACE;
					end
				end else if (func_q && hit_free) begin
					st_q <= rd.taken ? ST_OK : ST_BADFREE;
				end else begin
					idx_q <= idx_inc;
				end
			end
			S_NXT_CHK: begin
				nxt_q <= rd;
				nf_q  <= !rd.taken;
			end
			S_PRV_CHK: begin
				prv_q <= rd;
				pf_q  <= !rd.taken;
			end
			S_MERGE_WR: begin
				k_q   <= k_new;
				ptr_q <= idx_inc + CNT_W'(nf_q);
			end
			S_DN_WR: begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			S_UP_WR: begin
				ptr_q <= ptr_q - CNT_W'(1);
			end
			S_SPLIT_LO: begin
				st_q  <= ST_OK;
				pay_q <= cur_q.off + OFF_W'(HEADER_BYTES);
			end
			S_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_status_q <= st_q;
					rsp_pay_q    <= pay_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != '0 && total_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count out of range");

	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPLIT_HI |-> total_q < CNT_W'(MAX_BLOCKS))
		else $error("split started with a full table");

	a_rsp_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result raised outside the result state");

	a_fail_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != ST_OK |-> rsp_pay_q == '0)
		else $error("failed request carries a payload offset");

endmodule

// ----- sim/first_fit_heap_allocator_tb.sv -----
// Self-checking testbench of the first-fit heap allocator: a directed table, a fill up to the
// entry limit, then random allocate and release traffic, checked against an in-bench copy of the block table.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef struct {
		logic        fn;
		logic [15:0] bytes;
		logic [15:0] rel;
		logic        known;
		status_t     st;
		logic [15:0] off;
	} row_t;

	typedef struct {
		status_t     st;
		logic [15:0] off;
	} grant_t;

	logic clk, arst_n;
	logic req_valid, req_ready, func;
	logic [15:0] request_bytes, release_offset;
	logic rsp_valid, rsp_ready;
	logic [1:0] status;
	logic [15:0] payload_offset;

	logic [15:0] heap_off [MAX_BLOCKS];
	logic [16:0] heap_len [MAX_BLOCKS];
	logic        heap_used [MAX_BLOCKS];
	int          heap_count;

	grant_t      pending_grants[$];
	logic [15:0] live_offsets[$];
	int          failures;
	bit          calm;
	bit          hold_rsp;
	int          hold_cycles;

	first_fit_heap_allocator dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("first_fit_heap_allocator regression: fail");
		$finish;
	end

	function automatic void heap_drop(int k);
		for (int i = k; i + 1 < heap_count; i++) begin
			heap_off[i]  = heap_off[i+1];
			heap_len[i]  = heap_len[i+1];
			heap_used[i] = heap_used[i+1];
		end
		heap_count--;
	endfunction

	function automatic grant_t heap_alloc(logic [15:0] bytes);
		grant_t g;
		logic [16:0] need;
		g.off = '0;
		if (bytes == 0) begin
			g.st = ST_ZERO;
			return g;
		end
		need = 17'(((17'(bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES
			+ HEADER_BYTES);
		for (int i = 0; i < heap_count; i++) begin
			if (heap_used[i] || heap_len[i] < need) continue;
			if (heap_len[i] - need > HEADER_BYTES) begin
				if (heap_count >= MAX_BLOCKS) begin
					g.st = ST_NOSPACE;
					return g;
				end
				for (int j = heap_count; j > i + 1; j--) begin
					heap_off[j]  = heap_off[j-1];
					heap_len[j]  = heap_len[j-1];
					heap_used[j] = heap_used[j-1];
				end
				heap_off[i+1]  = heap_off[i] + 16'(need);
				heap_len[i+1]  = heap_len[i] - need;
				heap_used[i+1] = 1'b0;
				heap_len[i]    = need;
				heap_count++;
			end
			heap_used[i] = 1'b1;
			g.st  = ST_OK;
			g.off = heap_off[i] + 16'(HEADER_BYTES);
			return g;
		end
		g.st = ST_NOSPACE;
		return g;
	endfunction

	function automatic status_t heap_release(logic [15:0] rel);
		for (int i = 0; i < heap_count; i++) begin
			if (17'(heap_off[i]) + HEADER_BYTES != 17'(rel)) continue;
			if (!heap_used[i]) return ST_BADFREE;
			heap_used[i] = 1'b0;
			if (i + 1 < heap_count && !heap_used[i+1]) begin
				heap_len[i] += heap_len[i+1];
				heap_drop(i + 1);
			end
			if (i > 0 && !heap_used[i-1]) begin
				heap_len[i-1] += heap_len[i];
				heap_drop(i);
			end
			return ST_OK;
		end
		return ST_BADFREE;
	endfunction

	task automatic send_request(logic fn, logic [15:0] bytes, logic [15:0] rel,
			logic known, status_t st, logic [15:0] off);
		grant_t g;
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid      <= 1'b1;
		func           <= fn;
		request_bytes  <= bytes;
		release_offset <= rel;
		do @(posedge clk); while (!req_ready);
		if (fn == FN_ALLOC) begin
			g = heap_alloc(bytes);
			if (g.st == ST_OK) live_offsets.push_back(g.off);
		end else begin
			g.st  = heap_release(rel);
			g.off = '0;
			if (g.st == ST_OK)
				foreach (live_offsets[i])
					if (live_offsets[i] == rel) begin
						live_offsets.delete(i);
						break;
					end
		end
		if (known && (g.st != st || g.off != off)) begin
			$error("directed row: predictor gives %0d/%0d, table has %0d/%0d",
				g.st, g.off, st, off);
			failures++;
		end
		pending_grants.push_back(g);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		grant_t g;
		if (rsp_valid && rsp_ready) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected result status=%0d payload_offset=%0d", status, payload_offset);
				failures++;
			end else begin
				g = pending_grants.pop_front();
				if (status != g.st) begin
					$error("status: expected %0d, actual %0d", g.st, status);
					failures++;
				end
				if (payload_offset != g.off) begin
					$error("payload_offset: expected %0d, actual %0d", g.off, payload_offset);
					failures++;
				end
			end
		end
	end

	initial begin
		int burst;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 13);
				rsp_ready <= 1'b0;
				repeat (burst) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		row_t rows[$];
		logic [15:0] b, r;
		int pick;
		failures  = 0;
		calm      = 1'b0;
		hold_rsp  = 1'b0;
		heap_count = 1;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			heap_off[i] = '0; heap_len[i] = '0; heap_used[i] = 1'b0;
		end
		heap_len[0] = 17'(ARENA_BYTES);
		arst_n = 1'b0;
		req_valid = 1'b0; func = 1'b0; request_bytes = '0; release_offset = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{FN_FREE,  16'd0,     16'd16,    1, ST_BADFREE, 16'd0},
			'{FN_ALLOC, 16'd0,     16'd0,     1, ST_ZERO,    16'd0},
			'{FN_ALLOC, 16'd1,     16'd0,     1, ST_OK,      16'd16},
			'{FN_ALLOC, 16'd65535, 16'd0,     1, ST_NOSPACE, 16'd0},
			'{FN_FREE,  16'd0,     16'd0,     1, ST_BADFREE, 16'd0},
			'{FN_FREE,  16'd0,     16'd65535, 1, ST_BADFREE, 16'd0},
			'{FN_ALLOC, 16'd8,     16'd0,     0, ST_OK,      16'd0},
			'{FN_ALLOC, 16'd100,   16'd0,     0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd40,    0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd40,    1, ST_BADFREE, 16'd0},
			'{FN_ALLOC, 16'd16,    16'd0,     0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd16,    0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd64,    0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd184,   0, ST_OK,      16'd0},
			'{FN_ALLOC, 16'd65504, 16'd0,     0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd16,    0, ST_OK,      16'd0},
			'{FN_ALLOC, 16'd65520, 16'd0,     1, ST_OK,      16'd16},
			'{FN_FREE,  16'd0,     16'd16,    1, ST_OK,      16'd0},
			'{FN_ALLOC, 16'd65496, 16'd0,     0, ST_OK,      16'd0},
			'{FN_FREE,  16'd0,     16'd16,    0, ST_OK,      16'd0}
		};
		foreach (rows[i])
			send_request(rows[i].fn, rows[i].bytes, rows[i].rel,
				rows[i].known, rows[i].st, rows[i].off);

		// Fill the table so splits hit the entry limit, while the result side stalls.
		hold_cycles = 600;
		hold_rsp    = 1'b1;
		for (int i = 0; i < 70; i++)
			send_request(FN_ALLOC, 16'($urandom_range(1, 64)), 16'h0, 0, ST_OK, 16'h0);
		drain();
		repeat (20) @(posedge clk);
		for (int i = 0; i < 70; i += 2)
			if (live_offsets.size() > 0)
				send_request(FN_FREE, 16'h0, live_offsets[$urandom_range(0,
					live_offsets.size() - 1)], 0, ST_OK, 16'h0);

		for (int n = 0; n < 1760; n++) begin
			if (n == 1500) calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				case ($urandom_range(0, 9))
					0: b = 16'($urandom);
					1: b = 16'($urandom_range(0, 8));
					2: b = 16'($urandom_range(4000, 65535));
					default: b = 16'($urandom_range(1, 1500));
				endcase
				send_request(FN_ALLOC, b, 16'($urandom), 0, ST_OK, 16'h0);
			end else if (pick < 90 && live_offsets.size() > 0) begin
				r = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
				send_request(FN_FREE, 16'($urandom), r, 0, ST_OK, 16'h0);
			end else begin
				r = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255) * 8);
				send_request(FN_FREE, 16'($urandom), r, 0, ST_OK, 16'h0);
			end
		end
		drain();
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("first_fit_heap_allocator regression: pass");
		else
			$display("first_fit_heap_allocator regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ffha_pkg.sv
rtl/ffha_table.sv
rtl/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_tb.sv
